// ----- rtl/core/fsgd_pkg.sv -----
// Shared types, constants and arithmetic helpers for the grey dither block.
// Used by the top level and by the port checker; depends on nothing.
`timescale 1ns / 1ps

package fsgd_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 4096;
  localparam int unsigned CFG_W         = 13;
  localparam logic [CFG_W-1:0] DEFAULT_WIDTH = 13'd640;

  localparam logic [7:0] LEVEL_HIGH = 8'd255;
  localparam logic [7:0] LEVEL_LOW  = 8'd0;

  // Floyd-Steinberg weights, in sixteenths
  localparam logic [3:0] W_UPPER_LEFT  = 4'd1;
  localparam logic [3:0] W_UPPER       = 4'd5;
  localparam logic [3:0] W_UPPER_RIGHT = 4'd3;
  localparam logic [3:0] W_LEFT        = 4'd7;

  // floor(s / 3) for s < 2048 as (s * 683) >> 11
  localparam logic [9:0] DIV3_MUL   = 10'd683;
  localparam int unsigned DIV3_SHIFT = 11;

  typedef logic signed [8:0] err_t;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH = 1'b0
  } cfg_reg_e;

  // floor(e * w / 16)
  function automatic err_t share(input err_t e, input logic [3:0] w);
    logic signed [12:0] prod;
    logic signed [12:0] shifted;
    prod    = e * $signed({1'b0, w});
    shifted = prod >>> 4;
    return shifted[8:0];
  endfunction

  // v + d, clamped to 0..255
  function automatic logic [7:0] add_clamp(input logic [7:0] v, input err_t d);
    logic signed [9:0] sum;
    sum = $signed({2'b00, v}) + $signed({d[8], d});
    if (sum < 10'sd0) begin
      return LEVEL_LOW;
    end else if (sum > 10'sd255) begin
      return LEVEL_HIGH;
    end
    return sum[7:0];
  endfunction

endpackage

// ----- rtl/core/floyd_steinberg_grey_dither_top.sv -----
// 1-bit Floyd-Steinberg grey dither: RGB stream in, 0/255 stream out.
// A request is registered in the input stage, then the pixel stage writes its result into the result register.
// Throughput: 1 pixel per cycle while the master side accepts; the error update of the pixel stage is combinational.
// The line buffer is a single-port-write, single-read memory with registered read data.
// Reset clears control state, the width register (640) and the carried errors;
// the line buffer is not cleared, and the first row after reset or a frame start never reads it.
`timescale 1ns / 1ps

module floyd_steinberg_grey_dither_top #(
  parameter int unsigned MAX_WIDTH = fsgd_pkg::MAX_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  input  logic        s_axis_tuser,   // [0] start_of_frame
  // master stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_level
  output logic        m_axis_tlast,   // line_end
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WW = AW + 1;

  // configuration register
  logic [fsgd_pkg::CFG_W-1:0] width_q;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= fsgd_pkg::DEFAULT_WIDTH;
    end else if (cfg_wr && (paddr[2] == fsgd_pkg::REG_IMAGE_WIDTH)) begin
      width_q <= pwdata[fsgd_pkg::CFG_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      fsgd_pkg::REG_IMAGE_WIDTH: prdata = {{(32 - fsgd_pkg::CFG_W){1'b0}}, width_q};
      default:                   prdata = '0;
    endcase
  end

  logic [WW-1:0] w_use;

  always_comb begin
    if (width_q == '0) begin
      w_use = WW'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_use = WW'(MAX_WIDTH);
    end else begin
      w_use = WW'(width_q);
    end
  end

  // input stage: grey level and frame flag
  logic       s1_valid_q;
  logic [7:0] grey_q;
  logic       sof_q;
  logic       s_accept;
  logic       adv;
  logic       out_valid_q;
  logic [9:0] rgb_sum;
  logic [19:0] grey_prod;

  assign rgb_sum   = 10'(s_axis_tdata[7:0]) + 10'(s_axis_tdata[15:8])
                   + 10'(s_axis_tdata[23:16]);
  assign grey_prod = 20'(rgb_sum) * 20'(fsgd_pkg::DIV3_MUL);

  assign adv           = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || adv;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_accept) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      grey_q <= grey_prod[fsgd_pkg::DIV3_SHIFT +: 8];
      sof_q  <= s_axis_tuser;
    end
  end

  // pixel stage state
  logic [AW-1:0]   col_q;
  logic            first_q;
  fsgd_pkg::err_t  left_q;
  fsgd_pkg::err_t  ul_q;      // error above the previous column
  fsgd_pkg::err_t  ur_q;      // last upper-right error read
  fsgd_pkg::err_t  row0_q;    // copies of line buffer entries 0 and 1
  fsgd_pkg::err_t  row1_q;
  fsgd_pkg::err_t  rd_q;      // registered line buffer read, entry x+1 of next pixel

  fsgd_pkg::err_t  row_mem [MAX_WIDTH];

  logic [AW-1:0]   x;
  logic            first;
  logic            x_pos;
  logic            last;
  logic [AW:0]     x_inc;
  fsgd_pkg::err_t  e_ul;
  fsgd_pkg::err_t  e_up;
  fsgd_pkg::err_t  e_ur;
  fsgd_pkg::err_t  e_left;
  logic [7:0]      v1;
  logic [7:0]      v2;
  logic [7:0]      v3;
  logic [7:0]      v4;
  logic            q_high;
  fsgd_pkg::err_t  err;
  logic [AW-1:0]   rd_addr;

  always_comb begin
    x      = sof_q ? '0 : col_q;
    first  = sof_q || first_q;
    x_pos  = (x != '0);
    x_inc  = {1'b0, x} + (AW + 1)'(1);
    last   = (WW'(x_inc) >= w_use);
    rd_addr = AW'({1'b0, x} + (AW + 1)'(2));

    e_ul   = (!first && x_pos) ? ul_q : '0;
    e_up   = first ? '0 : (x_pos ? ur_q : row0_q);
    e_ur   = (first || last) ? '0 : (x_pos ? rd_q : row1_q);
    e_left = x_pos ? left_q : '0;

    // shares from the row above first, then from the left
    v1 = fsgd_pkg::add_clamp(grey_q, fsgd_pkg::share(e_ul, fsgd_pkg::W_UPPER_LEFT));
    v2 = fsgd_pkg::add_clamp(v1, fsgd_pkg::share(e_up, fsgd_pkg::W_UPPER));
    v3 = fsgd_pkg::add_clamp(v2, fsgd_pkg::share(e_ur, fsgd_pkg::W_UPPER_RIGHT));
    v4 = fsgd_pkg::add_clamp(v3, fsgd_pkg::share(e_left, fsgd_pkg::W_LEFT));

    q_high = v4[7];
    err    = q_high ? ($signed({1'b0, v4}) - $signed({1'b0, fsgd_pkg::LEVEL_HIGH}))
                    : $signed({1'b0, v4});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      first_q <= 1'b1;
      left_q  <= '0;
      ul_q    <= '0;
      ur_q    <= '0;
    end else if (adv) begin
      if (last) begin
        col_q   <= '0;
        first_q <= 1'b0;
        left_q  <= '0;
        ul_q    <= '0;
        ur_q    <= '0;
      end else begin
        col_q   <= x_inc[AW-1:0];
        first_q <= first;
        left_q  <= err;
        ul_q    <= e_up;
        ur_q    <= e_ur;
      end
    end
  end

  // line buffer: write this column, prefetch two columns ahead
  always_ff @(posedge clk_i) begin
    if (adv) begin
      row_mem[x] <= err;
      rd_q       <= row_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && (x == AW'(0))) begin
      row0_q <= err;
    end
    if (adv && (x == AW'(1))) begin
      row1_q <= err;
    end
  end

  // result register
  logic [7:0] level_q;
  logic       last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      level_q <= q_high ? fsgd_pkg::LEVEL_HIGH : fsgd_pkg::LEVEL_LOW;
      last_q  <= last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = level_q;
  assign m_axis_tlast  = last_q;

endmodule

// ----- rtl/core/fsgd_checker.sv -----
// Port-level checks for the grey dither top level, attached by bind.
// Depends on fsgd_pkg and sees only the top level's clock, reset and stream ports.
`timescale 1ns / 1ps

module fsgd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled result changed");

  // output is always a full black or full white level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata == fsgd_pkg::LEVEL_HIGH) ||
                       (m_axis_tdata == fsgd_pkg::LEVEL_LOW)))
    else $error("output level not 0 or 255");

  // input is only held off while a result waits on a stalled master side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output back-pressure");

  // an accepted request is followed by a valid result on the master side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> ##1 m_axis_tvalid)
    else $error("accepted request produced no result");

endmodule

bind floyd_steinberg_grey_dither_top fsgd_checker u_fsgd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
